// ===== sv/dll_pkg.sv =====
// Shared types and codes for the doubly linked list manager.
`default_nettype none
package dll_pkg;

    // operation codes
    localparam logic [3:0] FN_PUSH_FRONT = 4'd0;
    localparam logic [3:0] FN_PUSH_BACK  = 4'd1;
    localparam logic [3:0] FN_INS_AFTER  = 4'd2;
    localparam logic [3:0] FN_INS_BEFORE = 4'd3;
    localparam logic [3:0] FN_REMOVE     = 4'd4;
    localparam logic [3:0] FN_POP_FRONT  = 4'd5;
    localparam logic [3:0] FN_POP_BACK   = 4'd6;
    localparam logic [3:0] FN_READ       = 4'd7;
    localparam logic [3:0] FN_CLEAR      = 4'd8;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    // request sequencer states
    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_DEC, S_NB, S_W1, S_W2, S_W3, S_OUT
    } t_state;

endpackage
`default_nettype wire

// ===== sv/doubly_linked_list_manager_top.sv =====
// Top level of the doubly linked list manager.
//
// Usage: drive i_func, i_node_handle and i_value and raise start while
// busy is low; the request is taken at that edge. Exactly one result
// follows, shown for one cycle with o_done high; it cannot be held off.
// Sequence: every request, clear and error requests included, walks the
// same steps: read the addressed node, decode and read the free head's
// next link, update the bookkeeping registers; then W1 writes the new
// node links (neighbor links on removal), W2 points the neighbors at
// the new node (on removal, puts the node on the free list), W3 writes
// nothing and S_OUT shows the result. busy stays high through S_OUT, so
// a new request is accepted only after the last one is through.
// Reset: front, back and free list become none, the fresh counter zero
// and all allocated bits clear. Node memories keep contents; only entries
// of allocated nodes and the free head are read. Clear does the same.
`default_nettype none
module doubly_linked_list_manager_top
    import dll_pkg::*;
#(
    parameter int POOL_NODES = 64,
    parameter int DATA_BITS  = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    output logic        o_done,
    input  wire  [3:0]  i_func,
    input  wire  [5:0]  i_node_handle,
    input  wire  [31:0] i_value,
    output logic [1:0]  o_status,
    output logic [6:0]  o_node,
    output logic [31:0] o_node_value,
    output logic [6:0]  o_next_node,
    output logic [6:0]  o_prev_node,
    output logic [6:0]  o_front,
    output logic [6:0]  o_back,
    output logic        o_is_empty
);
    localparam int AW = $clog2(POOL_NODES);
    localparam int HW = $clog2(POOL_NODES + 1);
    localparam logic [HW-1:0] NONE = HW'(POOL_NODES);

    t_state r_st, n_st;
    logic [3:0]           r_func;
    logic [HW-1:0]        r_h;
    logic [DATA_BITS-1:0] r_val;
    logic [HW-1:0]        r_front, r_back, r_free, r_fresh;
    logic [POOL_NODES-1:0] r_alloc;
    logic [HW-1:0]        r_n, r_a, r_b;   // node, its next, its prev
    logic [1:0]           r_status;
    logic [DATA_BITS-1:0] r_rval;
    logic                 r_found;
    logic [DATA_BITS-1:0] r_data [POOL_NODES];
    logic [DATA_BITS-1:0] r_drd;

    // link memory ports
    logic          nx_we, pv_we;
    logic [AW-1:0] nx_wa, pv_wa, nx_ra, pv_ra;
    logic [HW-1:0] nx_wd, pv_wd, nx_rd, pv_rd;
    logic [AW-1:0] d_ra;

    dll_link_mem #(.POOL_NODES(POOL_NODES)) u_next (
        .i_clk(i_clk), .i_we(nx_we), .i_waddr(nx_wa), .i_wdata(nx_wd),
        .i_raddr(nx_ra), .o_rdata(nx_rd));
    dll_link_mem #(.POOL_NODES(POOL_NODES)) u_prev (
        .i_clk(i_clk), .i_we(pv_we), .i_waddr(pv_wa), .i_wdata(pv_wd),
        .i_raddr(pv_ra), .o_rdata(pv_rd));

    logic accept;
    assign accept = start && !busy;
    assign busy   = (r_st != S_IDLE);

    logic is_ins, is_rm, h_ok;
    assign is_ins = (r_func <= FN_INS_BEFORE);
    assign is_rm  = (r_func == FN_REMOVE) || (r_func == FN_POP_FRONT) ||
                    (r_func == FN_POP_BACK);
    assign h_ok   = (r_h < NONE) && r_alloc[r_h[AW-1:0]];

    // node addressed in the read cycle
    logic [HW-1:0] tgt;
    always_comb begin
        priority case (r_func)
            FN_POP_FRONT: tgt = r_front;
            FN_POP_BACK:  tgt = r_back;
            default:      tgt = r_h;
        endcase
    end

    // next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE:  if (accept) n_st = S_RD;
            S_RD:    n_st = S_DEC;
            S_DEC:   n_st = S_NB;
            S_NB:    n_st = S_W1;
            S_W1:    n_st = S_W2;
            S_W2:    n_st = S_W3;
            S_W3:    n_st = S_OUT;
            S_OUT:   n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    // memory read addresses: target in RD; free-head next in DEC
    always_comb begin
        nx_ra = tgt[AW-1:0];
        pv_ra = tgt[AW-1:0];
        d_ra  = tgt[AW-1:0];
        if (r_st == S_DEC) begin
            nx_ra = r_free[AW-1:0];
        end
    end

    // link writes: at most one next-link and one prev-link write in each write state
    logic          w_en_n, w_en_p;
    logic [HW-1:0] w_an, w_dn, w_ap, w_dp;
    always_comb begin
        w_en_n = 1'b0; w_en_p = 1'b0;
        w_an = r_n; w_dn = NONE; w_ap = r_n; w_dp = NONE;
        if (r_found && r_status == ST_OK) begin
            if (is_ins) begin
                unique case (r_st)
                    S_W1: begin   // new node links
                        w_en_n = 1'b1; w_an = r_n; w_dn = r_a;
                        w_en_p = 1'b1; w_ap = r_n; w_dp = r_b;
                    end
                    S_W2: begin   // neighbors point at new node
                        w_en_n = (r_b != NONE); w_an = r_b; w_dn = r_n;
                        w_en_p = (r_a != NONE); w_ap = r_a; w_dp = r_n;
                    end
                    default: ;
                endcase
            end else if (is_rm) begin
                unique case (r_st)
                    S_W1: begin
                        w_en_n = (r_b != NONE); w_an = r_b; w_dn = r_a;
                        w_en_p = (r_a != NONE); w_ap = r_a; w_dp = r_b;
                    end
                    S_W2: begin   // to free list
                        w_en_n = 1'b1; w_an = r_n; w_dn = r_free;
                    end
                    default: ;
                endcase
            end
        end
    end
    assign nx_we = w_en_n; assign nx_wa = w_an[AW-1:0]; assign nx_wd = w_dn;
    assign pv_we = w_en_p; assign pv_wa = w_ap[AW-1:0]; assign pv_wd = w_dp;

    // data memory
    always_ff @(posedge i_clk) begin
        if (r_st == S_W1 && r_found && r_status == ST_OK && is_ins) begin
            r_data[r_n[AW-1:0]] <= r_val;
        end
        r_drd <= r_data[d_ra];
    end

    // control and bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_front <= NONE; r_back <= NONE; r_free <= NONE;
            r_fresh <= '0; r_alloc <= '0; o_done <= 1'b0; r_found <= 1'b0;
        end else begin
            r_st   <= n_st;
            o_done <= 1'b0;
            unique case (r_st)
                S_IDLE: if (accept) begin
                    r_func <= i_func;
                    r_h    <= HW'(i_node_handle);
                    r_val  <= DATA_BITS'(i_value);
                end
                S_RD: begin
                    r_status <= ST_OK; r_found <= 1'b0; r_n <= NONE;
                    if (is_ins || r_func == FN_REMOVE || r_func == FN_READ) begin
                        if (r_func != FN_PUSH_FRONT && r_func != FN_PUSH_BACK
                            && !h_ok) r_status <= ST_BAD;
                        else r_found <= 1'b1;
                    end else if (r_func == FN_POP_FRONT || r_func == FN_POP_BACK) begin
                        if (tgt == NONE) r_status <= ST_EMPTY;
                        else r_found <= 1'b1;
                    end else if (r_func == FN_CLEAR) begin
                        r_front <= NONE; r_back <= NONE; r_free <= NONE;
                        r_fresh <= '0; r_alloc <= '0;
                    end
                end
                S_DEC: begin
                    // links of target are ready; free head next read now
                    if (r_found) begin
                        if (is_ins) begin
                            if (r_free != NONE || r_fresh < NONE) begin
                                r_n <= (r_free != NONE) ? r_free : r_fresh;
                                if (r_func == FN_PUSH_FRONT ||
                                    (r_func == FN_INS_BEFORE && pv_rd == NONE)) begin
                                    r_b <= NONE; r_a <= r_front;
                                end else if (r_func == FN_PUSH_BACK ||
                                    (r_func == FN_INS_AFTER && nx_rd == NONE)) begin
                                    r_a <= NONE; r_b <= r_back;
                                end else if (r_func == FN_INS_AFTER) begin
                                    r_b <= r_h; r_a <= nx_rd;
                                end else begin
                                    r_a <= r_h; r_b <= pv_rd;
                                end
                            end else begin
                                r_status <= ST_FULL; r_found <= 1'b0;
                            end
                        end else begin
                            r_n <= tgt; r_a <= nx_rd; r_b <= pv_rd;
                            r_rval <= r_drd;
                        end
                    end
                end
                S_NB: begin
                    if (r_found && is_ins) begin
                        r_alloc[r_n[AW-1:0]] <= 1'b1;
                        r_rval <= r_val;
                        if (r_free != NONE) r_free <= nx_rd;
                        else r_fresh <= r_fresh + 1'b1;
                        if (r_b == NONE) r_front <= r_n;
                        if (r_a == NONE) r_back  <= r_n;
                    end else if (r_found && is_rm) begin
                        r_alloc[r_n[AW-1:0]] <= 1'b0;
                        if (r_b == NONE) r_front <= r_a;
                        if (r_a == NONE) r_back  <= r_b;
                    end
                end
                S_W2: begin
                    if (r_found && is_rm) r_free <= r_n;
                end
                S_W3: o_done <= 1'b1;
                default: ;
            endcase
        end
    end

    // result outputs
    always_comb begin
        o_status     = r_status;
        o_node       = 7'(r_found ? r_n : NONE);
        o_node_value = r_found ? 32'(r_rval) : 32'd0;
        o_next_node  = 7'(r_found ? r_a : NONE);
        o_prev_node  = 7'(r_found ? r_b : NONE);
        o_front      = 7'(r_front);
        o_back       = 7'(r_back);
        o_is_empty   = (r_front == NONE);
    end
endmodule
`default_nettype wire

// ===== sv/dll_link_mem.sv =====
// Link memory: one link (next or prev) per node, one write port, one registered read port.
`default_nettype none
module dll_link_mem #(
    parameter int POOL_NODES = 64
) (
    input  wire                                i_clk,
    input  wire                                i_we,
    input  wire  [$clog2(POOL_NODES)-1:0]      i_waddr,
    input  wire  [$clog2(POOL_NODES+1)-1:0]    i_wdata,
    input  wire  [$clog2(POOL_NODES)-1:0]      i_raddr,
    output logic [$clog2(POOL_NODES+1)-1:0]    o_rdata
);
    logic [$clog2(POOL_NODES+1)-1:0] r_mem [POOL_NODES];

    // synchronous write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for the doubly linked list manager.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import dll_pkg::*;

    localparam logic [6:0] NIL = 7'd64;

    typedef struct packed {
        logic [1:0]  status;
        logic [6:0]  node;
        logic [31:0] node_value;
        logic [6:0]  next_node;
        logic [6:0]  prev_node;
        logic [6:0]  front;
        logic [6:0]  back;
        logic        is_empty;
    } t_list_reply;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        o_done;
    logic [3:0]  i_func;
    logic [5:0]  i_node_handle;
    logic [31:0] i_value;
    logic [1:0]  o_status;
    logic [6:0]  o_node;
    logic [31:0] o_node_value;
    logic [6:0]  o_next_node;
    logic [6:0]  o_prev_node;
    logic [6:0]  o_front;
    logic [6:0]  o_back;
    logic        o_is_empty;

    doubly_linked_list_manager_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .o_done(o_done), .i_func(i_func), .i_node_handle(i_node_handle),
        .i_value(i_value), .o_status(o_status), .o_node(o_node),
        .o_node_value(o_node_value), .o_next_node(o_next_node),
        .o_prev_node(o_prev_node), .o_front(o_front), .o_back(o_back),
        .o_is_empty(o_is_empty)
    );

    // shadow copy of the list
    logic [31:0] sh_data [64];
    logic [6:0]  sh_next [64];
    logic [6:0]  sh_prev [64];
    logic        sh_alloc [64];
    logic [6:0]  sh_front, sh_back, sh_free;
    logic [6:0]  sh_fresh;

    t_list_reply expected_replies [$];
    int          error_count = 0;
    int          reply_count = 0;
    int          request_count = 0;
    int          idle_pct = 0;

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    function automatic void shadow_clear();
        for (int k = 0; k < 64; k++) sh_alloc[k] = 1'b0;
        sh_front = NIL; sh_back = NIL; sh_free = NIL; sh_fresh = 7'd0;
    endfunction

    function automatic logic [6:0] shadow_alloc();
        logic [6:0] n;
        n = NIL;
        if (sh_free != NIL) begin
            n = sh_free;
            sh_free = sh_next[n[5:0]];
        end else if (sh_fresh < 7'd64) begin
            n = sh_fresh;
            sh_fresh = sh_fresh + 7'd1;
        end
        if (n != NIL) sh_alloc[n[5:0]] = 1'b1;
        return n;
    endfunction

    function automatic void shadow_unlink(logic [6:0] n);
        logic [6:0] b, a;
        b = sh_prev[n[5:0]];
        a = sh_next[n[5:0]];
        if (b == NIL) sh_front = a; else sh_next[b[5:0]] = a;
        if (a == NIL) sh_back = b; else sh_prev[a[5:0]] = b;
        sh_alloc[n[5:0]] = 1'b0;
        sh_next[n[5:0]] = sh_free;
        sh_free = n;
    endfunction

    // apply one request to the shadow list and return the expected reply
    function automatic t_list_reply predict_list_op(logic [3:0] f, logic [5:0] h,
                                                    logic [31:0] v);
        t_list_reply r;
        logic [6:0]  n, o, a, b;
        logic        ok;
        r = '0;
        r.node = NIL; r.next_node = NIL; r.prev_node = NIL;
        ok = sh_alloc[h];
        n = NIL;
        case (f)
            FN_PUSH_FRONT, FN_PUSH_BACK, FN_INS_AFTER, FN_INS_BEFORE: begin
                if ((f == FN_INS_AFTER || f == FN_INS_BEFORE) && !ok) begin
                    r.status = ST_BAD;
                end else begin
                    n = shadow_alloc();
                    if (n == NIL) begin
                        r.status = ST_FULL;
                    end else begin
                        sh_data[n[5:0]] = v;
                        if (f == FN_PUSH_FRONT || (f == FN_INS_BEFORE && sh_prev[h] == NIL)) begin
                            o = sh_front;
                            sh_prev[n[5:0]] = NIL; sh_next[n[5:0]] = o;
                            if (o == NIL) sh_back = n; else sh_prev[o[5:0]] = n;
                            sh_front = n;
                        end else if (f == FN_PUSH_BACK ||
                                     (f == FN_INS_AFTER && sh_next[h] == NIL)) begin
                            o = sh_back;
                            sh_next[n[5:0]] = NIL; sh_prev[n[5:0]] = o;
                            if (o == NIL) sh_front = n; else sh_next[o[5:0]] = n;
                            sh_back = n;
                        end else if (f == FN_INS_AFTER) begin
                            a = sh_next[h];
                            sh_prev[n[5:0]] = {1'b0, h}; sh_next[n[5:0]] = a;
                            sh_prev[a[5:0]] = n; sh_next[h] = n;
                        end else begin
                            b = sh_prev[h];
                            sh_prev[n[5:0]] = b; sh_next[n[5:0]] = {1'b0, h};
                            sh_next[b[5:0]] = n; sh_prev[h] = n;
                        end
                        r.node = n; r.node_value = sh_data[n[5:0]];
                        r.next_node = sh_next[n[5:0]]; r.prev_node = sh_prev[n[5:0]];
                    end
                end
            end
            FN_REMOVE, FN_POP_FRONT, FN_POP_BACK, FN_READ: begin
                if (f == FN_POP_FRONT) n = sh_front;
                else if (f == FN_POP_BACK) n = sh_back;
                else if (ok) n = {1'b0, h};
                if (n == NIL) begin
                    r.status = (f == FN_POP_FRONT || f == FN_POP_BACK) ? ST_EMPTY : ST_BAD;
                end else begin
                    r.node = n; r.node_value = sh_data[n[5:0]];
                    r.next_node = sh_next[n[5:0]]; r.prev_node = sh_prev[n[5:0]];
                    if (f != FN_READ) shadow_unlink(n);
                end
            end
            FN_CLEAR: shadow_clear();
            default: ;
        endcase
        r.front = sh_front;
        r.back = sh_back;
        r.is_empty = (sh_front == NIL);
        return r;
    endfunction

    // send one request; waits until busy is low again, start is lowered by the
    // next idle cycle or by drain
    task automatic send_request(logic [3:0] f, logic [5:0] h, logic [31:0] v);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_func <= f; i_node_handle <= h; i_value <= v;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        expected_replies.push_back(predict_list_op(f, h, v));
        request_count++;
    endtask

    // try up to eight random handles for an allocated one, else return any handle
    function automatic logic [5:0] pick_handle();
        logic [5:0] h;
        for (int t = 0; t < 8; t++) begin
            h = 6'($urandom_range(63));
            if (sh_alloc[h]) return h;
        end
        return 6'($urandom_range(63));
    endfunction

    // check each reply against the oldest expectation
    always @(posedge i_clk) begin
        t_list_reply got, want;
        if (i_rst_n && o_done) begin
            got = {o_status, o_node, o_node_value, o_next_node, o_prev_node,
                   o_front, o_back, o_is_empty};
            reply_count++;
            if (expected_replies.size() == 0) begin
                $display("%0t: unexpected reply %h", $time, got);
                error_count++;
            end else begin
                want = expected_replies.pop_front();
                if (got !== want) begin
                    error_count++;
                    $display("%0t: mismatch expected st=%0d node=%0d val=%h nx=%0d pv=%0d fr=%0d bk=%0d em=%0d",
                             $time, want.status, want.node, want.node_value, want.next_node,
                             want.prev_node, want.front, want.back, want.is_empty);
                    $display("%0t:          actual   st=%0d node=%0d val=%h nx=%0d pv=%0d fr=%0d bk=%0d em=%0d",
                             $time, got.status, got.node, got.node_value, got.next_node,
                             got.prev_node, got.front, got.back, got.is_empty);
                end
            end
        end
    end

    task automatic drain();
        start <= 1'b0;
        while (expected_replies.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_request(FN_POP_FRONT, 6'd0, 32'd0);        // empty pops
        send_request(FN_POP_BACK, 6'd0, 32'd0);
        send_request(FN_READ, 6'd63, 32'd0);            // bad handles
        send_request(FN_REMOVE, 6'd0, 32'd0);
        send_request(FN_INS_AFTER, 6'd5, 32'd1);
        send_request(FN_PUSH_FRONT, 6'd0, 32'hFFFF_FFFF);
        send_request(FN_PUSH_BACK, 6'd63, 32'h0000_0000);
        send_request(FN_PUSH_BACK, 6'd0, 32'hA5A5_5A5A);
        send_request(FN_INS_AFTER, 6'd0, 32'h1234_5678); // head end
        send_request(FN_INS_AFTER, 6'd2, 32'h0000_0001); // at back
        send_request(FN_INS_BEFORE, 6'd0, 32'h8000_0000); // at front
        send_request(FN_INS_BEFORE, 6'd2, 32'h5555_AAAA); // middle
        send_request(FN_READ, 6'd3, 32'd0);
        send_request(FN_REMOVE, 6'd3, 32'd0);
        send_request(FN_PUSH_FRONT, 6'd0, 32'h7777_0000); // reuses freed node
        send_request(FN_POP_FRONT, 6'd0, 32'd0);
        send_request(FN_POP_BACK, 6'd0, 32'd0);
        send_request(4'd9, 6'd0, 32'd0);                 // unused codes
        send_request(4'd15, 6'd63, 32'hFFFF_FFFF);
        send_request(FN_CLEAR, 6'd0, 32'd0);
        send_request(FN_CLEAR, 6'd0, 32'd0);             // clear when empty
        send_request(FN_READ, 6'd0, 32'd0);
        drain();
    endtask

    // fill the pool past capacity, then empty it through pops and removes
    task automatic test_pool_full();
        for (int k = 0; k < 66; k++)
            send_request(k[0] ? FN_PUSH_BACK : FN_INS_BEFORE, pick_handle(), $urandom());
        send_request(FN_INS_AFTER, pick_handle(), $urandom());
        for (int k = 0; k < 66; k++)
            send_request(k % 3 == 0 ? FN_POP_FRONT : (k % 3 == 1 ? FN_POP_BACK : FN_REMOVE),
                         pick_handle(), 32'd0);
        drain();
    endtask

    task automatic test_random(int count, int pct);
        logic [3:0] f;
        int         sel;
        idle_pct = pct;
        for (int k = 0; k < count; k++) begin
            sel = $urandom_range(99);
            if (sel < 25) f = 4'(FN_PUSH_FRONT + $urandom_range(1));
            else if (sel < 45) f = 4'(FN_INS_AFTER + $urandom_range(1));
            else if (sel < 60) f = FN_REMOVE;
            else if (sel < 75) f = 4'(FN_POP_FRONT + $urandom_range(1));
            else if (sel < 92) f = FN_READ;
            else if (sel < 94) f = FN_CLEAR;
            else f = 4'($urandom_range(15));
            send_request(f, ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : pick_handle(),
                         $urandom());
        end
        drain();
        idle_pct = 0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_func = '0;
        i_node_handle = '0;
        i_value = '0;
        shadow_clear();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_pool_full();
        test_random(450, 0);
        test_random(400, 49);
        test_random(400, 16);
        test_random(300, 0);
        if (expected_replies.size() != 0) begin
            $display("%0t: %0d replies missing", $time, expected_replies.size());
            error_count++;
        end
        $display("Ran %0d list requests, %0d replies checked, pool fill and drain included.",
                 request_count, reply_count);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("FAIL");
        $finish;
    end

endmodule
`default_nettype wire
